@@ design/sjf_pkg.sv @@
`default_nettype none

package sjf_pkg;

	localparam int MAX_JOBS_DEF  = 16;
	localparam int TIME_BITS_DEF = 16;

	// Request operation codes.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} sjf_state_t;

	typedef struct packed {
		logic        op;
		logic [15:0] arrival_time;
		logic [15:0] burst_length;
	} sjf_req_t;

	typedef struct packed {
		logic        load_rejected;
		logic        ran;
		logic [3:0]  job_index;
		logic        finished;
		logic [15:0] finish_time;
	} sjf_rsp_t;

	typedef struct packed {
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [15:0] remaining;
	} sjf_entry_t;

endpackage

`default_nettype wire

@@ design/shortest_job_first_scheduler.sv @@
`default_nettype none

// Shortest-job-first scheduler. A request is taken when start is high and busy is low; a
// load request (op = OP_LOAD) writes one job into the next free table slot, and a tick
// request (op = OP_TICK) runs one time unit of the arrived, unfinished job with the
// smallest original burst, lowest slot winning ties, then advances the saturating clock.
// Every request produces exactly one result, shown on result for a single cycle while
// done is high; the receiver cannot stall, so sample it then. A load is written in the
// cycle it is taken, busy stays low, and its result appears in the next cycle. A tick
// walks the job table in a synchronous RAM with one write and one registered read port,
// one slot per cycle; busy stays high while it compares the last slot read, closes the
// scan and writes back the chosen job (with an empty table the scan closes at once), and
// done rises in the cycle after the write-back. The next request may be issued in the
// same cycle that done is high.
module shortest_job_first_scheduler #(
	parameter int MAX_JOBS  = sjf_pkg::MAX_JOBS_DEF,
	parameter int TIME_BITS = sjf_pkg::TIME_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire sjf_pkg::sjf_req_t request,
	output logic                  done,
	output sjf_pkg::sjf_rsp_t      result
);

	import sjf_pkg::*;

	localparam int IDX_W = $clog2(MAX_JOBS);
	localparam int CNT_W = $clog2(MAX_JOBS + 1);
	// Arrival times are 16 bits; the clock may be wider or narrower.
	localparam int CMP_W = (TIME_BITS > 16) ? TIME_BITS : 16;

	// Job table: arrival, original burst and remaining work per slot.
	sjf_entry_t mem [MAX_JOBS];
	sjf_entry_t mem_rdata;

	sjf_state_t state_q, state_d;

	logic [CNT_W-1:0]     job_count_q;
	logic [TIME_BITS-1:0] time_q;
	logic [TIME_BITS-1:0] time_next;

	// Scan bookkeeping. rd_ptr_q can reach the job count itself.
	logic [CNT_W-1:0] rd_ptr_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             found_q;
	logic [IDX_W-1:0] best_idx_q;
	sjf_entry_t       best_q;

	logic       accept;
	logic       rd_en;
	logic       scan_done;
	logic       table_full;
	logic       eligible;
	logic [CMP_W-1:0] arr_ext;
	logic [CMP_W-1:0] time_ext;
	logic [CMP_W-1:0] fin_ext;

	sjf_entry_t       wr_data;
	logic [IDX_W-1:0] wr_addr;
	logic             wr_en;

	logic       done_q;
	sjf_rsp_t   result_q;
	sjf_rsp_t   result_d;

	assign accept     = start && (state_q == ST_IDLE);
	assign table_full = (job_count_q == CNT_W'(MAX_JOBS));
	assign time_next  = (time_q == {TIME_BITS{1'b1}}) ? time_q : time_q + 1'b1;

	assign arr_ext  = CMP_W'(mem_rdata.arrival);
	assign time_ext = CMP_W'(time_q);
	assign fin_ext  = CMP_W'(time_next);

	// A slot takes part if it still has work, has arrived, and beats the best so far.
	// Strict less-than keeps the earliest slot on equal bursts.
	assign eligible = rd_vld_s1 && (mem_rdata.remaining != 16'd0) && (arr_ext <= time_ext)
		&& (!found_q || (mem_rdata.burst < best_q.burst));

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (request.op == OP_TICK)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control outputs and memory port selection.
	always_comb begin
		busy      = 1'b1;
		rd_en     = 1'b0;
		scan_done = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = best_idx_q;
		wr_data   = best_q;
		case (state_q)
			ST_IDLE: begin
				busy    = 1'b0;
				wr_addr = job_count_q[IDX_W-1:0];
				wr_data = '{arrival: request.arrival_time,
					burst: request.burst_length,
					remaining: request.burst_length};
				wr_en   = accept && (request.op == OP_LOAD) && !table_full;
			end
			ST_SCAN: begin
				rd_en     = (rd_ptr_q < job_count_q);
				scan_done = !rd_en && !rd_vld_s1;
			end
			ST_COMMIT: begin
				wr_addr           = best_idx_q;
				wr_data           = best_q;
				wr_data.remaining = best_q.remaining - 16'd1;
				wr_en             = found_q;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// Result of the request being finished: a load answer in the idle state, else
	// the outcome of the tick being written back.
	always_comb begin
		result_d = '0;
		if (state_q == ST_COMMIT) begin
			if (found_q) begin
				result_d.ran       = 1'b1;
				result_d.job_index = 4'((IDX_W + 4)'(best_idx_q));
				// Work reaches zero this tick: the job completes at the next time step.
				if (best_q.remaining == 16'd1) begin
					result_d.finished    = 1'b1;
					result_d.finish_time = fin_ext[15:0];
				end
			end
		end else begin
			result_d.load_rejected = table_full;
			if (!table_full) begin
				result_d.job_index = 4'((IDX_W + 4)'(job_count_q[IDX_W-1:0]));
			end
		end
	end

	// Job table RAM: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rdata <= mem[rd_ptr_q[IDX_W-1:0]];
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_count_q <= '0;
			time_q      <= '0;
			rd_ptr_q    <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			case (state_q)
				ST_IDLE: begin
					rd_ptr_q <= '0;
					found_q  <= 1'b0;
					done_q   <= accept && (request.op == OP_LOAD);
					if (accept && (request.op == OP_LOAD) && !table_full) begin
						job_count_q <= job_count_q + 1'b1;
					end
				end
				ST_SCAN: begin
					done_q <= 1'b0;
					if (rd_en) begin
						rd_ptr_q <= rd_ptr_q + 1'b1;
					end
					if (eligible) begin
						found_q <= 1'b1;
					end
				end
				ST_COMMIT: begin
					done_q <= 1'b1;
					time_q <= time_next;
				end
				default: begin
					done_q <= 1'b0;
				end
			endcase
		end
	end

	// Scan payload and the result register.
	always_ff @(posedge clk) begin
		idx_s1 <= rd_ptr_q[IDX_W-1:0];
		if (eligible) begin
			best_idx_q <= idx_s1;
			best_q     <= mem_rdata;
		end
		if ((state_q == ST_IDLE && accept && (request.op == OP_LOAD))
				|| (state_q == ST_COMMIT)) begin
			result_q <= result_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire
